// File: rtl/fpa_pkg.sv
// shared types and codes for the handle pool allocator
`default_nettype none

package fpa_pkg;

    localparam int HANDLE_W = 6;
    localparam int OP_W     = 2;
    localparam int STAT_W   = 2;
    localparam int MAX_TRACKED = 64;

    localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
    localparam logic [OP_W-1:0] OP_TRY     = 2'd1;
    localparam logic [OP_W-1:0] OP_DEALLOC = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY     = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EXHAUSTED = 2'd2;
    localparam logic [STAT_W-1:0] STAT_NOT_ALLOC = 2'd3;

    typedef struct packed {
        logic load;
        logic commit;
    } fpa_cmd_t;

    typedef struct packed {
        logic out_full;
    } fpa_stat_t;

endpackage

`default_nettype wire

// File: rtl/fpa_ram.sv
// generic single-port-write ram with registered read
`default_nettype none

module fpa_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// File: rtl/fpa_ctrl.sv
// request sequencer for the handle pool allocator
`default_nettype none

module fpa_ctrl
    import fpa_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_tvalid,
    output logic           s_tready,
    output fpa_cmd_t       cmd,
    input  wire fpa_stat_t stat
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t state_reg, state_next;

    assign s_tready   = (state_reg == S_IDLE);
    assign cmd.load   = s_tvalid && s_tready;
    assign cmd.commit = (state_reg == S_EXEC) && !stat.out_full;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (cmd.load) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (cmd.commit) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/fpa_dp.sv
// free list, allocated bitmap, mint counter and result register
`default_nettype none

module fpa_dp
    import fpa_pkg::*;
#(
    parameter int POOL_SIZE = 64
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire fpa_cmd_t            cmd,
    output fpa_stat_t                stat,
    input  wire logic [OP_W-1:0]     opcode,
    input  wire logic [HANDLE_W-1:0] handle_in,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [HANDLE_W-1:0]      handle_out,
    output logic [STAT_W-1:0]        status
);

    localparam int FD = (POOL_SIZE < MAX_TRACKED) ? POOL_SIZE : MAX_TRACKED;
    localparam int PW = $clog2(FD);
    localparam int CW = $clog2(FD + 1);
    localparam int MW = $clog2(POOL_SIZE + 1);

    logic [OP_W-1:0]     op_reg;
    logic [HANDLE_W-1:0] hin_reg;
    logic [PW-1:0]       head_reg, head_next;
    logic [PW-1:0]       tail_reg, tail_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [MW-1:0]       minted_reg, minted_next;
    logic [FD-1:0]       bm_reg, bm_next;
    logic                out_valid_reg;
    logic [HANDLE_W-1:0] out_handle_reg, out_handle_next;
    logic [STAT_W-1:0]   out_status_reg, out_status_next;

    logic                push;
    logic [HANDLE_W-1:0] pop_handle;
    logic                hin_in_range;

    fpa_ram #(
        .WIDTH(HANDLE_W),
        .DEPTH(FD)
    ) u_free_ram (
        .aclk    (aclk),
        .wr_en   (push),
        .wr_addr (tail_reg),
        .wr_data (hin_reg),
        .rd_addr (head_reg),
        .rd_data (pop_handle)
    );

    assign hin_in_range  = (32'(hin_reg) < POOL_SIZE);
    assign stat.out_full = out_valid_reg && !m_tready;

    always_comb begin
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        minted_next     = minted_reg;
        bm_next         = bm_reg;
        push            = 1'b0;
        out_handle_next = '0;
        out_status_next = STAT_NOT_ALLOC;
        if (cmd.commit) begin
            if (op_reg == OP_ALLOC || op_reg == OP_TRY) begin
                if (count_reg != '0) begin
                    head_next  = (head_reg == PW'(FD - 1)) ? '0 : head_reg + 1'b1;
                    count_next = count_reg - 1'b1;
                    bm_next[pop_handle[PW-1:0]] = 1'b1;
                    out_handle_next = pop_handle;
                    out_status_next = STAT_OK;
                end else if (op_reg == OP_TRY) begin
                    out_status_next = STAT_EMPTY;
                end else if (minted_reg < MW'(POOL_SIZE)) begin
                    minted_next = minted_reg + 1'b1;
                    if (minted_reg < MW'(FD)) begin
                        bm_next[minted_reg[PW-1:0]] = 1'b1;
                    end
                    out_handle_next = HANDLE_W'(minted_reg);
                    out_status_next = STAT_OK;
                end else begin
                    out_status_next = STAT_EXHAUSTED;
                end
            end else if (op_reg == OP_DEALLOC) begin
                out_handle_next = hin_reg;
                if (hin_in_range && bm_reg[hin_reg[PW-1:0]]) begin
                    bm_next[hin_reg[PW-1:0]] = 1'b0;
                    out_status_next = STAT_OK;
                    if (count_reg < CW'(FD)) begin
                        push       = 1'b1;
                        tail_next  = (tail_reg == PW'(FD - 1)) ? '0 : tail_reg + 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            minted_reg    <= '0;
            bm_reg        <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            count_reg  <= count_next;
            minted_reg <= minted_next;
            bm_reg     <= bm_next;
            if (cmd.commit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg  <= opcode;
            hin_reg <= handle_in;
        end
        if (cmd.commit) begin
            out_handle_reg <= out_handle_next;
            out_status_reg <= out_status_next;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign handle_out = out_handle_reg;
    assign status     = out_status_reg;

endmodule

`default_nettype wire

// File: rtl/fifo_handle_pool_allocator_top.sv
// top level of the fifo free-list handle pool allocator
//
// channel   dir  handshake           payload
// s_*       in   s_tvalid/s_tready   s_tdata: opcode[1:0], handle_in[7:2]
// m_*       out  m_tvalid/m_tready   m_tdata: handle_out[5:0], status[7:6]
//
// each request is accepted, then executed: the execute state reads the
// free list head from the ram's registered port and updates list and bitmap
// one request in flight; the next is accepted while the result waits in m_tdata
// execute holds while an untaken result still sits in the output register
// aresetn (synchronous) empties the free list and clears all allocated bits
`default_nettype none

module fifo_handle_pool_allocator_top
    import fpa_pkg::*;
#(
    parameter int POOL_SIZE = 64
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // opcode, handle_in
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata    // handle_out, status
);

    fpa_cmd_t            cmd;
    fpa_stat_t           stat;
    logic [HANDLE_W-1:0] handle_out;
    logic [STAT_W-1:0]   status;

    fpa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    fpa_dp #(
        .POOL_SIZE(POOL_SIZE)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .opcode     (s_tdata[1:0]),
        .handle_in  (s_tdata[7:2]),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .handle_out (handle_out),
        .status     (status)
    );

    assign m_tdata = {status, handle_out};

endmodule

`default_nettype wire

// File: rtl/fpa_checker.sv
// port-level checks for the handle pool allocator, bound to the top level
`default_nettype none

module fpa_checker
    import fpa_pkg::*;
(
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_tvalid,
    input wire logic       s_tready,
    input wire logic [7:0] s_tdata,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while another is executing");

    a_result_after_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result without an executing request");

    a_fail_zero_handle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[7:6] == STAT_EMPTY || m_tdata[7:6] == STAT_EXHAUSTED)
            |-> m_tdata[5:0] == '0)
        else $error("failed allocate returned a nonzero handle");

    a_dealloc_echo: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tdata[1:0] == OP_DEALLOC && m_tready
            |=> ##1 m_tvalid && m_tdata[5:0] == $past(s_tdata[7:2], 2))
        else $error("deallocate result does not echo the handle");

endmodule

bind fifo_handle_pool_allocator_top fpa_checker u_fpa_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// File: sim/tb_fifo_handle_pool_allocator_top.sv
// self-checking testbench for the fifo free-list handle pool allocator
`timescale 1ns / 100ps

module tb_fifo_handle_pool_allocator_top;
    import fpa_pkg::*;

    localparam int POOL        = 64;
    localparam int PLAN_VIEW   = 0;
    localparam int CHECK_VIEW  = 1;
    localparam int STALL_LIMIT = 2000;
    localparam int LONG_HOLD   = 300;
    localparam int MAX_REPORTS = 200;
    localparam int RANDOM_REQS = 1090;
    localparam logic [OP_W-1:0] OP_NONE = 2'd3;

    typedef struct packed {
        logic [STAT_W-1:0]   status;
        logic [HANDLE_W-1:0] handle;
    } pool_result_t;

    typedef struct packed {
        logic                wait_drain;
        logic [HANDLE_W-1:0] handle;
        logic [OP_W-1:0]     op;
    } pool_req_t;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;   // opcode[1:0], handle_in[7:2]
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;            // handle_out[5:0], status[7:6]

    // two copies of the pool state: one steers the stimulus, one checks the block
    logic [HANDLE_W-1:0] free_slots [2][POOL];
    logic [HANDLE_W-1:0] list_head  [2];
    logic [HANDLE_W-1:0] list_tail  [2];
    logic [6:0]          list_count [2];
    logic [6:0]          minted     [2];
    logic [POOL-1:0]     alloc_map  [2];

    pool_req_t    pending_reqs[$];
    pool_result_t expected_results[$];

    int errors       = 0;
    int stall_cycles = 0;
    int gap_left     = 0;
    int burst_left   = 0;
    int hold_left    = 0;
    int mode         = 0;
    int mode_left    = 0;
    int results_seen = 0;
    bit long_hold_done = 1'b0;
    pool_req_t    next_req;
    pool_result_t got_pred;
    pool_result_t want;

    fifo_handle_pool_allocator_top #(.POOL_SIZE(POOL)) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    function automatic void clear_pool(int side);
        list_head[side]  = '0;
        list_tail[side]  = '0;
        list_count[side] = '0;
        minted[side]     = '0;
        alloc_map[side]  = '0;
    endfunction

    function automatic pool_result_t grant_or_release(int side, logic [OP_W-1:0] op,
                                                      logic [HANDLE_W-1:0] hin);
        pool_result_t r;
        logic [HANDLE_W-1:0] h;
        r.handle = '0;
        r.status = STAT_NOT_ALLOC;
        if (op == OP_ALLOC || op == OP_TRY) begin
            if (list_count[side] != 0) begin
                h = free_slots[side][list_head[side]];
                list_head[side]  = list_head[side] + 1'b1;
                list_count[side] = list_count[side] - 1'b1;
                alloc_map[side][h] = 1'b1;
                r.handle = h;
                r.status = STAT_OK;
            end else if (op == OP_TRY) begin
                r.status = STAT_EMPTY;
            end else if (minted[side] < POOL) begin
                h = minted[side][HANDLE_W-1:0];
                minted[side] = minted[side] + 1'b1;
                alloc_map[side][h] = 1'b1;
                r.handle = h;
                r.status = STAT_OK;
            end else begin
                r.status = STAT_EXHAUSTED;
            end
        end else if (op == OP_DEALLOC) begin
            r.handle = hin;
            if (alloc_map[side][hin]) begin
                alloc_map[side][hin] = 1'b0;
                if (list_count[side] < POOL) begin
                    free_slots[side][list_tail[side]] = hin;
                    list_tail[side]  = list_tail[side] + 1'b1;
                    list_count[side] = list_count[side] + 1'b1;
                end
                r.status = STAT_OK;
            end
        end
        return r;
    endfunction

    task automatic queue_request(logic [OP_W-1:0] op, logic [HANDLE_W-1:0] hin, logic drain);
        pool_req_t req;
        req.op = op;
        req.handle = hin;
        req.wait_drain = drain;
        void'(grant_or_release(PLAN_VIEW, op, hin));
        pending_reqs.push_back(req);
    endtask

    function automatic logic [HANDLE_W-1:0] pick_allocated();
        int start;
        int idx;
        start = $urandom_range(0, POOL - 1);
        for (int i = 0; i < POOL; i++) begin
            idx = (start + i) % POOL;
            if (alloc_map[PLAN_VIEW][idx])
                return idx[HANDLE_W-1:0];
        end
        return HANDLE_W'($urandom_range(0, POOL - 1));
    endfunction

    // stimulus and end of run
    initial begin
        int phase;
        int phase_left;
        int roll;
        int made;
        logic drain;
        logic [HANDLE_W-1:0] any_handle;
        clear_pool(PLAN_VIEW);
        clear_pool(CHECK_VIEW);

        queue_request(OP_TRY, 6'd63, 1'b0);
        queue_request(OP_DEALLOC, 6'd0, 1'b0);
        queue_request(OP_DEALLOC, 6'd63, 1'b0);
        queue_request(OP_NONE, 6'd63, 1'b0);
        queue_request(OP_NONE, 6'd0, 1'b0);
        queue_request(OP_ALLOC, 6'd0, 1'b0);
        queue_request(OP_ALLOC, 6'd63, 1'b0);
        queue_request(OP_ALLOC, 6'd21, 1'b0);
        queue_request(OP_DEALLOC, 6'd1, 1'b0);
        queue_request(OP_DEALLOC, 6'd1, 1'b0);
        queue_request(OP_DEALLOC, 6'd0, 1'b0);
        queue_request(OP_TRY, 6'd42, 1'b0);
        queue_request(OP_ALLOC, 6'd0, 1'b0);
        queue_request(OP_ALLOC, 6'd0, 1'b0);
        queue_request(OP_TRY, 6'd0, 1'b0);
        queue_request(OP_DEALLOC, 6'd40, 1'b0);

        made = 0;
        phase = 0;
        phase_left = 0;
        while (made < RANDOM_REQS) begin
            if (phase_left == 0) begin
                phase = $urandom_range(0, 2);
                phase_left = $urandom_range(20, 120);
            end
            phase_left--;
            drain = (made % 250 == 0);
            roll = $urandom_range(0, 99);
            any_handle = HANDLE_W'($urandom_range(0, POOL - 1));
            case (phase)
                0: begin
                    if (roll < 70)      queue_request(OP_ALLOC, any_handle, drain);
                    else if (roll < 80) queue_request(OP_TRY, any_handle, drain);
                    else if (roll < 92) queue_request(OP_DEALLOC, pick_allocated(), drain);
                    else if (roll < 97) queue_request(OP_DEALLOC, any_handle, drain);
                    else                queue_request(OP_NONE, any_handle, drain);
                end
                1: begin
                    if (roll < 60)      queue_request(OP_DEALLOC, pick_allocated(), drain);
                    else if (roll < 75) queue_request(OP_TRY, any_handle, drain);
                    else if (roll < 85) queue_request(OP_ALLOC, any_handle, drain);
                    else if (roll < 95) queue_request(OP_DEALLOC, any_handle, drain);
                    else                queue_request(OP_NONE, any_handle, drain);
                end
                default: begin
                    if (roll < 35)      queue_request(OP_ALLOC, any_handle, drain);
                    else if (roll < 55) queue_request(OP_TRY, any_handle, drain);
                    else if (roll < 85) queue_request(OP_DEALLOC, pick_allocated(), drain);
                    else if (roll < 96) queue_request(OP_DEALLOC, any_handle, drain);
                    else                queue_request(OP_NONE, any_handle, drain);
                end
            endcase
            made++;
        end

        aresetn = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_reqs.size() > 0 || s_tvalid || expected_results.size() > 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("tb_fifo_handle_pool_allocator_top OK");
        end else begin
            $display("tb_fifo_handle_pool_allocator_top NOT OK");
        end
        $finish;
    end

    // request driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                got_pred = grant_or_release(CHECK_VIEW, s_tdata[1:0], s_tdata[7:2]);
                expected_results.push_back(got_pred);
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    next_req = pending_reqs[0];
                    if (next_req.wait_drain && expected_results.size() > 0) begin
                        s_tvalid <= 1'b0;
                    end else begin
                        void'(pending_reqs.pop_front());
                        s_tvalid <= 1'b1;
                        s_tdata  <= {next_req.handle, next_req.op};
                        if (burst_left > 1) begin
                            burst_left--;
                        end else begin
                            burst_left = $urandom_range(1, 24);
                            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                        end
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result receiver stall pattern
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready)
                results_seen++;
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (!long_hold_done && results_seen >= 200) begin
                long_hold_done = 1'b1;
                hold_left = LONG_HOLD;
                m_tready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(10, 80);
                end else begin
                    mode_left--;
                end
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    2:       m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected result, actual %h", $time, m_tdata);
            end else begin
                want = expected_results.pop_front();
                if (m_tdata[5:0] !== want.handle) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: handle_out expected %0d actual %0d",
                                 $time, want.handle, m_tdata[5:0]);
                end
                if (m_tdata[7:6] !== want.status) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, m_tdata[7:6]);
                end
            end
        end
    end

    // watchdog on cycles with no request or result moving
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("tb_fifo_handle_pool_allocator_top NOT OK");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

endmodule
